/* hw/rtl/npc_pkg.sv */
`default_nettype none

package npc_pkg;

  // Palette depth default and fixed field widths
  localparam int NpcEntriesDef = 16;
  localparam int ColorW        = 8;
  localparam int RgbW          = 3 * ColorW;
  localparam int SqW           = 2 * ColorW;
  localparam int DistW         = 18;
  localparam int SizeW         = 5;
  localparam int EntryIdxW     = 4;

  // Start value of the running minimum: one above the largest distance
  localparam logic [DistW-1:0] DistStart = DistW'(255 * 255 * 3 + 1);

  // Item function codes
  typedef enum logic [0:0] {
    FuncLoad  = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StWait
  } state_e;

  // Control that travels with each palette entry down the scan pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/npc_palette_mem.sv */
`default_nettype none

module npc_palette_mem #(
  parameter int Depth = npc_pkg::NpcEntriesDef,
  parameter int AddrW = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic [npc_pkg::RgbW-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output logic      [npc_pkg::RgbW-1:0] rdata_o
);

  logic [npc_pkg::RgbW-1:0] mem_q [Depth];
  logic [npc_pkg::RgbW-1:0] rdata_q;

  // Write one entry per load
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, one entry per cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/npc_dist_unit.sv */
`default_nettype none

module npc_dist_unit #(
  parameter int IdxW = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire npc_pkg::scan_ctl_t         ctl_i,
  input  wire logic [IdxW-1:0]            idx_i,
  input  wire logic [npc_pkg::RgbW-1:0]   entry_i,
  input  wire logic [npc_pkg::ColorW-1:0] q_red_i,
  input  wire logic [npc_pkg::ColorW-1:0] q_green_i,
  input  wire logic [npc_pkg::ColorW-1:0] q_blue_i,
  output npc_pkg::scan_ctl_t              ctl_o,
  output logic      [IdxW-1:0]            idx_o,
  output logic      [npc_pkg::RgbW-1:0]   color_o,
  output logic      [npc_pkg::DistW-1:0]  dist_o
);

  localparam int CW = npc_pkg::ColorW;
  localparam int SW = npc_pkg::SqW;
  localparam int DW = npc_pkg::DistW;

  logic [CW-1:0] e_red, e_green, e_blue;
  logic [CW-1:0] ad_red, ad_green, ad_blue;

  npc_pkg::scan_ctl_t        ctl1_q, ctl2_q;
  logic [IdxW-1:0]           idx1_q, idx2_q;
  logic [npc_pkg::RgbW-1:0]  col1_q, col2_q;
  logic [SW-1:0]             sq_red_q, sq_green_q, sq_blue_q;
  logic [DW-1:0]             dist_q;

  assign e_red   = entry_i[3*CW-1:2*CW];
  assign e_green = entry_i[2*CW-1:CW];
  assign e_blue  = entry_i[CW-1:0];

  // Absolute component differences
  assign ad_red   = (q_red_i > e_red)     ? (q_red_i - e_red)     : (e_red - q_red_i);
  assign ad_green = (q_green_i > e_green) ? (q_green_i - e_green) : (e_green - q_green_i);
  assign ad_blue  = (q_blue_i > e_blue)   ? (q_blue_i - e_blue)   : (e_blue - q_blue_i);

  // Advance the control through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Stage one squares each difference, stage two sums them
  always_ff @(posedge clk_i) begin
    idx1_q     <= idx_i;
    col1_q     <= entry_i;
    sq_red_q   <= SW'(ad_red)   * SW'(ad_red);
    sq_green_q <= SW'(ad_green) * SW'(ad_green);
    sq_blue_q  <= SW'(ad_blue)  * SW'(ad_blue);
    idx2_q     <= idx1_q;
    col2_q     <= col1_q;
    dist_q     <= DW'(sq_red_q) + DW'(sq_green_q) + DW'(sq_blue_q);
  end

  assign ctl_o   = ctl2_q;
  assign idx_o   = idx2_q;
  assign color_o = col2_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

/* hw/rtl/nearest_palette_color.sv */
// Nearest palette color matcher. A load beat (func_i = 0) writes one palette
// entry; a query beat (func_i = 1) scans entries 0 to min(palette size,
// PALETTE_ENTRIES) - 1 in order and returns the first entry with the smallest
// squared RGB distance. A scan keeps busy high until its result is issued, so
// the next query is taken only after the last one is through: the scan reads
// one entry per cycle through the single palette read port and the shared
// distance unit, then waits for the read and distance pipeline to drain.
// A query on an empty palette answers in the next cycle with valid_res_o = 0.
// Each result is shown for exactly one cycle with res_valid_o high; the
// receiver cannot stall it, so it must take every result beat as it comes.
// Write the palette size only while busy is low; read only entries loaded
// since reset.

`default_nettype none

module nearest_palette_color #(
  parameter int PALETTE_ENTRIES = npc_pkg::NpcEntriesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [0:0]                    func_i,
  input  wire logic [npc_pkg::EntryIdxW-1:0] entry_index_i,
  input  wire logic [npc_pkg::ColorW-1:0]    red_i,
  input  wire logic [npc_pkg::ColorW-1:0]    green_i,
  input  wire logic [npc_pkg::ColorW-1:0]    blue_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [npc_pkg::SizeW-1:0]     cfg_data_i,
  output logic                               res_valid_o,
  output logic                               valid_res_o,
  output logic      [npc_pkg::EntryIdxW-1:0] match_index_o,
  output logic      [npc_pkg::ColorW-1:0]    match_red_o,
  output logic      [npc_pkg::ColorW-1:0]    match_green_o,
  output logic      [npc_pkg::ColorW-1:0]    match_blue_o,
  output logic      [npc_pkg::DistW-1:0]     distance_o
);

  localparam int AddrW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CntW   = $clog2(PALETTE_ENTRIES + 1);
  localparam int SatW   = (CntW > npc_pkg::SizeW) ? CntW : npc_pkg::SizeW;
  localparam int WideW  = (AddrW > npc_pkg::EntryIdxW) ? AddrW : npc_pkg::EntryIdxW;
  localparam int WideP1 = WideW + 1;
  localparam int CW     = npc_pkg::ColorW;
  localparam int DW     = npc_pkg::DistW;
  localparam int IW     = npc_pkg::EntryIdxW;

  localparam logic [SatW-1:0]   EntriesSat  = SatW'(PALETTE_ENTRIES);
  localparam logic [WideP1-1:0] EntriesWide = WideP1'(PALETTE_ENTRIES);

  npc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d, count_q, count_d, count_sat;
  logic [npc_pkg::SizeW-1:0] size_q;
  logic [SatW-1:0]         size_ext;

  logic                    accept, is_load, is_query;
  logic [WideW-1:0]        slot_wide;
  logic                    slot_ok, mem_we;

  logic                    rd_en;
  npc_pkg::scan_ctl_t      rd_ctl, rd_ctl_q;
  logic [AddrW-1:0]        rd_idx_q;
  logic [npc_pkg::RgbW-1:0] rd_data;

  logic [CW-1:0]           q_red_q, q_green_q, q_blue_q;

  npc_pkg::scan_ctl_t      dist_ctl;
  logic [AddrW-1:0]        dist_idx;
  logic [npc_pkg::RgbW-1:0] dist_col;
  logic [DW-1:0]           dist_val;

  logic [DW-1:0]           best_dist_q, nb_dist;
  logic [AddrW-1:0]        best_idx_q, nb_idx;
  logic [npc_pkg::RgbW-1:0] best_col_q, nb_col;
  logic                    better;
  logic [WideW-1:0]        nb_idx_wide;

  logic                    res_fire, res_empty;
  logic                    res_valid_q, valid_res_q;
  logic [IW-1:0]           match_index_q;
  logic [npc_pkg::RgbW-1:0] match_col_q;
  logic [DW-1:0]           distance_q;

  // Handshake and item decode
  assign busy        = (state_q != npc_pkg::StIdle);
  assign cfg_ready_o = ~busy;
  assign accept      = start & ~busy;
  assign is_load     = accept & (func_i == npc_pkg::FuncLoad);
  assign is_query    = accept & (func_i == npc_pkg::FuncQuery);

  // Drop loads beyond the store
  assign slot_wide = WideW'(entry_index_i);
  assign slot_ok   = ({1'b0, slot_wide} < EntriesWide);
  assign mem_we    = is_load & slot_ok;

  // Saturate the scan count at the store depth
  assign size_ext  = SatW'(size_q);
  assign count_sat = (size_ext > EntriesSat) ? CntW'(EntriesSat) : CntW'(size_ext);

  // Sequencer: issue one read per cycle, then wait for the pipeline to drain
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    rd_en     = 1'b0;
    rd_ctl    = '0;
    res_fire  = 1'b0;
    res_empty = 1'b0;
    case (state_q)
      npc_pkg::StIdle: begin
        if (is_query) begin
          count_d = count_sat;
          cnt_d   = '0;
          if (count_sat == '0) begin
            res_empty = 1'b1;
          end else begin
            state_d = npc_pkg::StIssue;
          end
        end
      end
      npc_pkg::StIssue: begin
        rd_en       = 1'b1;
        rd_ctl.vld  = 1'b1;
        rd_ctl.last = (cnt_q == (count_q - CntW'(1)));
        cnt_d       = cnt_q + CntW'(1);
        if (rd_ctl.last) begin
          state_d = npc_pkg::StWait;
        end
      end
      npc_pkg::StWait: begin
        if (dist_ctl.vld && dist_ctl.last) begin
          res_fire = 1'b1;
          state_d  = npc_pkg::StIdle;
        end
      end
      default: begin
        state_d = npc_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npc_pkg::StIdle;
      cnt_q       <= '0;
      count_q     <= '0;
      size_q      <= '0;
      rd_ctl_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      rd_ctl_q    <= rd_ctl;
      res_valid_q <= res_fire | res_empty;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  npc_palette_mem #(
    .Depth(PALETTE_ENTRIES),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(slot_wide[AddrW-1:0]),
    .wdata_i({red_i, green_i, blue_i}),
    .re_i   (rd_en),
    .raddr_i(cnt_q[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  // Hold the query color and tag each read with its index
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[AddrW-1:0];
    if (is_query) begin
      q_red_q   <= red_i;
      q_green_q <= green_i;
      q_blue_q  <= blue_i;
    end
  end

  npc_dist_unit #(
    .IdxW(AddrW)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rd_ctl_q),
    .idx_i    (rd_idx_q),
    .entry_i  (rd_data),
    .q_red_i  (q_red_q),
    .q_green_i(q_green_q),
    .q_blue_i (q_blue_q),
    .ctl_o    (dist_ctl),
    .idx_o    (dist_idx),
    .color_o  (dist_col),
    .dist_o   (dist_val)
  );

  // Keep the first entry with the strictly smallest distance
  assign better      = (dist_val < best_dist_q);
  assign nb_dist     = better ? dist_val : best_dist_q;
  assign nb_idx      = better ? dist_idx : best_idx_q;
  assign nb_col      = better ? dist_col : best_col_q;
  assign nb_idx_wide = WideW'(nb_idx);

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      best_dist_q <= npc_pkg::DistStart;
    end else if (dist_ctl.vld) begin
      best_dist_q <= nb_dist;
      best_idx_q  <= nb_idx;
      best_col_q  <= nb_col;
    end
  end

  // Result register: one beat per query
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      valid_res_q   <= 1'b1;
      match_index_q <= nb_idx_wide[IW-1:0];
      match_col_q   <= nb_col;
      distance_q    <= nb_dist;
    end else if (res_empty) begin
      valid_res_q   <= 1'b0;
      match_index_q <= '0;
      match_col_q   <= '0;
      distance_q    <= '0;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign valid_res_o   = valid_res_q;
  assign match_index_o = match_index_q;
  assign match_red_o   = match_col_q[3*CW-1:2*CW];
  assign match_green_o = match_col_q[2*CW-1:CW];
  assign match_blue_o  = match_col_q[CW-1:0];
  assign distance_o    = distance_q;

endmodule

`default_nettype wire

/* verif/nearest_palette_color_test.sv */
module nearest_palette_color_test;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int Entries     = NpcEntriesDef;
  localparam int QuietCycles = Entries + 8;
  localparam int CycleLimit  = 400000;

  // Kinds of work the driver pulls from its queue
  typedef enum logic [1:0] {
    OpBeat,
    OpSize,
    OpDrain
  } op_kind_e;

  typedef struct {
    op_kind_e              kind;
    func_e                 func;
    logic [EntryIdxW-1:0]  slot;
    logic [RgbW-1:0]       rgb;
    logic [SizeW-1:0]      size;
    int                    idle_pct;
  } stim_op_t;

  typedef struct packed {
    logic                  valid;
    logic [EntryIdxW-1:0]  index;
    logic [RgbW-1:0]       rgb;
    logic [DistW-1:0]      sq_dist;
  } match_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic [0:0]            func_i        = FuncLoad;
  logic [EntryIdxW-1:0]  entry_index_i = '0;
  logic [ColorW-1:0]     red_i         = '0;
  logic [ColorW-1:0]     green_i       = '0;
  logic [ColorW-1:0]     blue_i        = '0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [SizeW-1:0]      cfg_data_i    = '0;
  logic                  res_valid_o;
  logic                  valid_res_o;
  logic [EntryIdxW-1:0]  match_index_o;
  logic [ColorW-1:0]     match_red_o;
  logic [ColorW-1:0]     match_green_o;
  logic [ColorW-1:0]     match_blue_o;
  logic [DistW-1:0]      distance_o;

  nearest_palette_color dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (res_valid_o),
    .valid_res_o   (valid_res_o),
    .match_index_o (match_index_o),
    .match_red_o   (match_red_o),
    .match_green_o (match_green_o),
    .match_blue_o  (match_blue_o),
    .distance_o    (distance_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  stim_op_t        stim_q[$];
  logic [RgbW-1:0] plan_palette [Entries];
  logic [RgbW-1:0] palette_model [Entries];
  logic [SizeW-1:0] size_model = '0;
  match_t          match_q[$];
  int              outstanding = 0;
  int              quiet       = 0;
  int              errors      = 0;
  int              n_loads     = 0;
  int              n_queries   = 0;
  int              n_empty     = 0;
  int              n_sizes     = 0;
  int              cycle_count = 0;

  // Nearest entry among the searched ones; strict compare keeps the lowest index on a tie
  function automatic match_t nearest_match(logic [RgbW-1:0] color);
    match_t          best;
    logic [RgbW-1:0] entry;
    int              count, dr, dg, db, d;
    best  = '0;
    count = (size_model > Entries) ? Entries : int'(size_model);
    if (count == 0) return best;
    best.valid   = 1'b1;
    best.sq_dist = DistStart;
    for (int i = 0; i < count; i++) begin
      entry = palette_model[i];
      dr = int'(color[23:16]) - int'(entry[23:16]);
      dg = int'(color[15:8])  - int'(entry[15:8]);
      db = int'(color[7:0])   - int'(entry[7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < int'(best.sq_dist)) begin
        best.sq_dist = DistW'(d);
        best.index   = EntryIdxW'(i);
        best.rgb     = entry;
      end
    end
    return best;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Colors biased toward extremes, coarse levels and copies of loaded entries
  function automatic logic [RgbW-1:0] pick_color();
    logic [ColorW-1:0] levels [3];
    levels = '{8'h00, 8'h80, 8'hFF};
    case ($urandom_range(9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2, 3: return plan_palette[$urandom_range(Entries - 1)];
      4, 5: return {levels[$urandom_range(2)], levels[$urandom_range(2)],
                    levels[$urandom_range(2)]};
      default: return RgbW'($urandom);
    endcase
  endfunction

  task automatic add_beat(func_e func, logic [EntryIdxW-1:0] slot, logic [RgbW-1:0] rgb,
                          int idle_pct);
    stim_op_t op;
    op = '{OpBeat, func, slot, rgb, '0, idle_pct};
    if (func == FuncLoad) plan_palette[slot] = rgb;
    stim_q.push_back(op);
  endtask

  task automatic add_size(logic [SizeW-1:0] size);
    stim_op_t op;
    op = '{OpSize, FuncLoad, '0, '0, size, 0};
    stim_q.push_back(op);
  endtask

  task automatic add_drain();
    stim_op_t op;
    op = '{OpDrain, FuncLoad, '0, '0, '0, 0};
    stim_q.push_back(op);
  endtask

  // Driver: hold start until the beat is taken, write the size only when idle
  always @(posedge clk_i) begin : drive
    logic     took, next_start, next_cfg_valid;
    stim_op_t op;
    if (rst_ni) begin
      took           = start && !busy;
      next_start     = start && !took;
      next_cfg_valid = cfg_valid_i && !cfg_ready_o;
      quiet <= took ? 0 : quiet + 1;
      if (!next_start && !next_cfg_valid && stim_q.size() > 0) begin
        op = stim_q[0];
        case (op.kind)
          OpBeat: begin
            if ($urandom_range(99) >= op.idle_pct) begin
              func_i        <= op.func;
              entry_index_i <= op.slot;
              red_i         <= op.rgb[23:16];
              green_i       <= op.rgb[15:8];
              blue_i        <= op.rgb[7:0];
              next_start     = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          OpSize: begin
            if (!took && !busy && outstanding == 0 && quiet >= QuietCycles) begin
              cfg_data_i    <= op.size;
              next_cfg_valid = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            if (!took && outstanding == 0) void'(stim_q.pop_front());
          end
        endcase
      end
      start       <= next_start;
      cfg_valid_i <= next_cfg_valid;
    end
  end

  // Monitor: check result beats, then track size writes and accepted beats
  always @(posedge clk_i) begin : watch
    match_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (match_q.size() == 0) begin
          $error("result beat with no query outstanding");
          errors++;
        end else begin
          want = match_q.pop_front();
          check_field("valid_res",   want.valid,        valid_res_o);
          check_field("match_index", want.index,        match_index_o);
          check_field("match_red",   want.rgb[23:16],   match_red_o);
          check_field("match_green", want.rgb[15:8],    match_green_o);
          check_field("match_blue",  want.rgb[7:0],     match_blue_o);
          check_field("distance",    want.sq_dist,      distance_o);
          if (!want.valid) n_empty++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        size_model = cfg_data_i;
        n_sizes++;
      end
      if (start && !busy) begin
        if (func_i == FuncLoad) begin
          palette_model[entry_index_i] = {red_i, green_i, blue_i};
          n_loads++;
        end else begin
          match_q.push_back(nearest_match({red_i, green_i, blue_i}));
          n_queries++;
        end
      end
      outstanding <= match_q.size();
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SizeW-1:0] phase_size [8];
    int               idle_pcts [3];
    logic [RgbW-1:0]  rgb;

    // Reset size: query on an empty palette before anything is loaded
    add_beat(FuncQuery, 4'hF, 24'h123456, 0);

    // Fill every slot; slot 5 repeats slot 3 so the lower index must win the tie
    add_beat(FuncLoad, 4'd0, 24'h000000, 0);
    add_beat(FuncLoad, 4'd1, 24'hFFFFFF, 0);
    add_beat(FuncLoad, 4'd2, 24'hFF0000, 0);
    add_beat(FuncLoad, 4'd3, 24'h00FF00, 0);
    add_beat(FuncLoad, 4'd4, 24'h0000FF, 0);
    add_beat(FuncLoad, 4'd5, 24'h00FF00, 0);
    for (int i = 6; i < Entries; i++) begin
      rgb = {ColorW'(i * 16), ColorW'(255 - i * 16), ColorW'(i * 5)};
      add_beat(FuncLoad, EntryIdxW'(i), rgb, 0);
    end

    // Full palette: exact hits and the duplicate-entry tie
    add_size(SizeW'(Entries));
    add_beat(FuncQuery, 4'h0, 24'h000000, 0);
    add_beat(FuncQuery, 4'hF, 24'hFFFFFF, 0);
    add_beat(FuncQuery, 4'h5, 24'h00FF00, 0);
    add_beat(FuncQuery, 4'hA, 24'h0A141E, 0);

    // Single entry: largest possible distance
    add_size(5'd1);
    add_beat(FuncQuery, 4'h0, 24'hFFFFFF, 0);
    add_beat(FuncQuery, 4'h3, 24'h000000, 0);

    // Oversized size saturates at the store depth
    add_size(5'd31);
    add_beat(FuncQuery, 4'h7, 24'h0000FF, 0);

    // Random phases across sizes and sender idle rates
    phase_size = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, SizeW'($urandom_range(15, 2)), 5'd16,
                   SizeW'($urandom_range(15, 2))};
    idle_pcts  = '{0, 45, 13};
    for (int p = 0; p < 8; p++) begin
      add_size(phase_size[p]);
      for (int k = 0; k < 75; k++) begin
        if (k == 37) add_drain();
        if ($urandom_range(99) < 30)
          add_beat(FuncLoad, EntryIdxW'($urandom), pick_color(), idle_pcts[p % 3]);
        else
          add_beat(FuncQuery, EntryIdxW'($urandom), pick_color(), idle_pcts[p % 3]);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all beats taken, all results in, then let the pipeline settle
    while (stim_q.size() != 0 || start) @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);

    $display("covered %0d loads, %0d queries (%0d on an empty palette), %0d size writes",
             n_loads, n_queries, n_empty, n_sizes);
    $display("sizes 0, 1, 16 and oversized, ties, extreme distances, sender idle 0/13/45%%");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/npc_pkg.sv
hw/rtl/npc_palette_mem.sv
hw/rtl/npc_dist_unit.sv
hw/rtl/nearest_palette_color.sv
verif/nearest_palette_color_test.sv
